### rtl/sri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_pkg: shared types for the segment/rectangle hit test
// Sign flags, the flag bundle between the prepare and decide stages, corner
// indexes and the sign-agreement helpers.
// ----------------------------------------------------------------------------
package sri_pkg;

  localparam int NUM_CORNERS = 4;

  // corner indexes: left/right x, top/bottom y
  localparam int CORNER_00 = 0;
  localparam int CORNER_10 = 1;
  localparam int CORNER_01 = 2;
  localparam int CORNER_11 = 3;

  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  typedef struct packed {
    logic [NUM_CORNERS-1:0] box;
    sign_t rx;
    sign_t ry;
    sign_t dx0;
    sign_t dx1;
    sign_t dy0;
    sign_t dy1;
    sign_t ex0;
    sign_t ex1;
    sign_t ey0;
    sign_t ey1;
    logic  w_nz;
    logic  h_nz;
  } flags_t;

  // product of signs is non-negative
  function automatic logic agree(sign_t a, logic b_neg);
    return a.zero || (a.neg == b_neg);
  endfunction

  // product of signs is non-positive
  function automatic logic oppose(sign_t a, logic b_neg);
    return a.zero || (a.neg != b_neg);
  endfunction

endpackage
`default_nettype wire

### rtl/sri_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_in_if: segment/rectangle pair channel
// Valid/ready channel carrying one segment and one rectangle per transaction.
// ----------------------------------------------------------------------------
interface sri_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic        [COORD_BITS-2:0] rect_width;
  logic        [COORD_BITS-2:0] rect_height;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           rect_x, rect_y, rect_width, rect_height,
    input  ready
  );

  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           rect_x, rect_y, rect_width, rect_height,
    output ready
  );
endinterface
`default_nettype wire

### rtl/sri_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_out_if: hit result channel
// Valid/ready channel carrying one hit flag per transaction.
// ----------------------------------------------------------------------------
interface sri_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface
`default_nettype wire

### rtl/sri_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_prep: input register and product stage
// Registers the incoming pair, then forms the four corner cross-product
// terms and the sign, zero and bounding-box flags into a second register.
// ----------------------------------------------------------------------------
module sri_prep #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  sri_in_if.sink                            pair,
  input  wire logic                         take,
  output logic                              valid,
  output logic signed [2*COORD_BITS+3:0]    p_rx_dy0,
  output logic signed [2*COORD_BITS+3:0]    p_rx_dy1,
  output logic signed [2*COORD_BITS+3:0]    p_ry_dx0,
  output logic signed [2*COORD_BITS+3:0]    p_ry_dx1,
  output sri_pkg::flags_t                   flags
);

  localparam int DW = COORD_BITS + 2;
  localparam int PW = 2 * DW;

  logic                         in_valid;
  logic                         in_ready;
  logic                         prod_ready;
  logic signed [COORD_BITS-1:0] r_sx;
  logic signed [COORD_BITS-1:0] r_sy;
  logic signed [COORD_BITS-1:0] r_ex;
  logic signed [COORD_BITS-1:0] r_ey;
  logic signed [COORD_BITS-1:0] r_x0;
  logic signed [COORD_BITS-1:0] r_y0;
  logic        [COORD_BITS-2:0] r_w;
  logic        [COORD_BITS-2:0] r_h;

  logic signed [DW-1:0] sx, sy, ex, ey, x0, y0, x1, y1;
  logic signed [DW-1:0] rx, ry, dx0, dx1, dy0, dy1;
  logic signed [DW-1:0] ex0, ex1, ey0, ey1;
  sri_pkg::flags_t      flags_next;

  function automatic logic between(logic signed [DW-1:0] v, logic signed [DW-1:0] a,
                                   logic signed [DW-1:0] b);
    return ((v >= a) && (v <= b)) || ((v >= b) && (v <= a));
  endfunction

  function automatic sri_pkg::sign_t sign_of(logic signed [DW-1:0] v);
    sri_pkg::sign_t s;
    s.neg  = v[DW-1];
    s.zero = (v == '0);
    return s;
  endfunction

  assign prod_ready = !valid || take;
  assign in_ready   = !in_valid || prod_ready;
  assign pair.ready = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && pair.valid) begin
      r_sx <= pair.seg_start_x;
      r_sy <= pair.seg_start_y;
      r_ex <= pair.seg_end_x;
      r_ey <= pair.seg_end_y;
      r_x0 <= pair.rect_x;
      r_y0 <= pair.rect_y;
      r_w  <= pair.rect_width;
      r_h  <= pair.rect_height;
    end
  end

  always_comb begin
    sx  = DW'(r_sx);
    sy  = DW'(r_sy);
    ex  = DW'(r_ex);
    ey  = DW'(r_ey);
    x0  = DW'(r_x0);
    y0  = DW'(r_y0);
    x1  = x0 + signed'(DW'(r_w));
    y1  = y0 + signed'(DW'(r_h));
    rx  = ex - sx;
    ry  = ey - sy;
    dx0 = x0 - sx;
    dx1 = x1 - sx;
    dy0 = y0 - sy;
    dy1 = y1 - sy;
    ex0 = ex - x0;
    ex1 = ex - x1;
    ey0 = ey - y0;
    ey1 = ey - y1;

    flags_next.box[sri_pkg::CORNER_00] = between(x0, sx, ex) && between(y0, sy, ey);
    flags_next.box[sri_pkg::CORNER_10] = between(x1, sx, ex) && between(y0, sy, ey);
    flags_next.box[sri_pkg::CORNER_01] = between(x0, sx, ex) && between(y1, sy, ey);
    flags_next.box[sri_pkg::CORNER_11] = between(x1, sx, ex) && between(y1, sy, ey);
    flags_next.rx   = sign_of(rx);
    flags_next.ry   = sign_of(ry);
    flags_next.dx0  = sign_of(dx0);
    flags_next.dx1  = sign_of(dx1);
    flags_next.dy0  = sign_of(dy0);
    flags_next.dy1  = sign_of(dy1);
    flags_next.ex0  = sign_of(ex0);
    flags_next.ex1  = sign_of(ex1);
    flags_next.ey0  = sign_of(ey0);
    flags_next.ey1  = sign_of(ey1);
    flags_next.w_nz = (r_w != '0);
    flags_next.h_nz = (r_h != '0);
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (prod_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      p_rx_dy0 <= PW'(rx) * PW'(dy0);
      p_rx_dy1 <= PW'(rx) * PW'(dy1);
      p_ry_dx0 <= PW'(ry) * PW'(dx0);
      p_ry_dx1 <= PW'(ry) * PW'(dx1);
      flags    <= flags_next;
    end
  end

endmodule
`default_nettype wire

### rtl/sri_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sri_decide: cross products, side tests and result register
// Completes the corner cross products, evaluates the corner and four side
// tests by sign comparison and holds the hit flag for the result channel.
// ----------------------------------------------------------------------------
module sri_decide #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid,
  input  wire logic signed [2*COORD_BITS+3:0] p_rx_dy0,
  input  wire logic signed [2*COORD_BITS+3:0] p_rx_dy1,
  input  wire logic signed [2*COORD_BITS+3:0] p_ry_dx0,
  input  wire logic signed [2*COORD_BITS+3:0] p_ry_dx1,
  input  wire sri_pkg::flags_t              flags,
  output logic                              take,
  sri_out_if.source                         result
);

  localparam int CW = 2 * COORD_BITS + 5;

  logic signed [CW-1:0] c00, c10, c01, c11;
  sri_pkg::sign_t       s00, s10, s01, s11;
  logic                 corner_hit;
  logic                 side_a, side_b, side_c, side_d;
  logic                 hit_next;

  always_comb begin
    c00 = CW'(p_rx_dy0) - CW'(p_ry_dx0);
    c10 = CW'(p_rx_dy0) - CW'(p_ry_dx1);
    c01 = CW'(p_rx_dy1) - CW'(p_ry_dx0);
    c11 = CW'(p_rx_dy1) - CW'(p_ry_dx1);
    s00 = '{neg: c00[CW-1], zero: (c00 == '0)};
    s10 = '{neg: c10[CW-1], zero: (c10 == '0)};
    s01 = '{neg: c01[CW-1], zero: (c01 == '0)};
    s11 = '{neg: c11[CW-1], zero: (c11 == '0)};

    corner_hit = (flags.box[sri_pkg::CORNER_00] && s00.zero) ||
                 (flags.box[sri_pkg::CORNER_10] && s10.zero) ||
                 (flags.box[sri_pkg::CORNER_01] && s01.zero) ||
                 (flags.box[sri_pkg::CORNER_11] && s11.zero);

    // top side, left to right
    side_a = flags.w_nz && !flags.ry.zero &&
             sri_pkg::agree(flags.dy0, flags.ry.neg) &&
             sri_pkg::agree(flags.ey0, flags.ry.neg) &&
             sri_pkg::agree(s00, flags.ry.neg) &&
             sri_pkg::oppose(s10, flags.ry.neg);
    // right side, downwards
    side_b = flags.h_nz && !flags.rx.zero &&
             sri_pkg::agree(flags.dx1, flags.rx.neg) &&
             sri_pkg::agree(flags.ex1, flags.rx.neg) &&
             sri_pkg::oppose(s10, flags.rx.neg) &&
             sri_pkg::agree(s11, flags.rx.neg);
    // bottom side, right to left
    side_c = flags.w_nz && !flags.ry.zero &&
             sri_pkg::agree(flags.dy1, flags.ry.neg) &&
             sri_pkg::agree(flags.ey1, flags.ry.neg) &&
             sri_pkg::oppose(s11, flags.ry.neg) &&
             sri_pkg::agree(s01, flags.ry.neg);
    // left side, upwards
    side_d = flags.h_nz && !flags.rx.zero &&
             sri_pkg::agree(flags.dx0, flags.rx.neg) &&
             sri_pkg::agree(flags.ex0, flags.rx.neg) &&
             sri_pkg::agree(s01, flags.rx.neg) &&
             sri_pkg::oppose(s00, flags.rx.neg);

    hit_next = corner_hit || side_a || side_b || side_c || side_d;
  end

  assign take = !result.valid || result.ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && valid) begin
      result.hit <= hit_next;
    end
  end

endmodule
`default_nettype wire

### rtl/segment_rectangle_intersect_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_core: segment versus rectangle hit test
// Pipeline: a pair transaction reaches result valid through the input register,
// the product register and the result register.
// Throughput: one pair per cycle; a waiting result stalls new pairs only
// once the input, product and result registers all hold a transaction.
// Reset: synchronous, clears the three stage valid flags only.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  sri_in_if.sink    pair,
  sri_out_if.source result
);

  logic                           prod_valid;
  logic                           take;
  logic signed [2*COORD_BITS+3:0] p_rx_dy0;
  logic signed [2*COORD_BITS+3:0] p_rx_dy1;
  logic signed [2*COORD_BITS+3:0] p_ry_dx0;
  logic signed [2*COORD_BITS+3:0] p_ry_dx1;
  sri_pkg::flags_t                flags;

  sri_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .pair     (pair),
    .take     (take),
    .valid    (prod_valid),
    .p_rx_dy0 (p_rx_dy0),
    .p_rx_dy1 (p_rx_dy1),
    .p_ry_dx0 (p_ry_dx0),
    .p_ry_dx1 (p_ry_dx1),
    .flags    (flags)
  );

  sri_decide #(
    .COORD_BITS(COORD_BITS)
  ) u_decide (
    .clk      (clk),
    .rst      (rst),
    .valid    (prod_valid),
    .p_rx_dy0 (p_rx_dy0),
    .p_rx_dy1 (p_rx_dy1),
    .p_ry_dx0 (p_ry_dx0),
    .p_ry_dx1 (p_ry_dx1),
    .flags    (flags),
    .take     (take),
    .result   (result)
  );

endmodule
`default_nettype wire

### tb/segment_rectangle_intersect_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_core_tb: self-checking bench for the hit test
// A queue-fed driver offers segment/rectangle pairs and a monitor checks each
// hit flag against an in-bench exact-arithmetic prediction. The bench runs
// directed corner, collinear and degenerate cases, then shaped random pairs
// under several idle and stall mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect_core_tb;

  localparam int COORD_BITS  = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 219;

  typedef struct {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic        [COORD_BITS-2:0] w;
    logic        [COORD_BITS-2:0] h;
  } pair_t;

  typedef struct {
    pair_t p;
    logic  hit;
  } hit_entry_t;

  logic clk;
  logic rst;

  sri_in_if #(.COORD_BITS(COORD_BITS)) pair_if ();
  sri_out_if result_if ();

  segment_rectangle_intersect_core #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .pair  (pair_if.sink),
    .result(result_if.source)
  );

  pair_t      pending_pairs[$];
  hit_entry_t hit_queue[$];
  pair_t      offered;
  int         send_idle_pct;
  int         stall_pct;
  int         errors;
  int         hold_left;
  logic       hold_request;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic signed [COORD_BITS-1:0] to_coord(int v);
    return COORD_BITS'(v);
  endfunction

  function automatic logic [COORD_BITS-2:0] to_size(int v);
    return (COORD_BITS-1)'(v);
  endfunction

  function automatic int sgn(longint v);
    return (v < 0) ? -1 : ((v != 0) ? 1 : 0);
  endfunction

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic bit side_crossed(longint px, longint py, longint qx, longint qy,
                                      longint ax, longint ay, longint bx, longint by);
    longint dsx, dsy, dax, day, wx, wy, den, tn, un;
    int     ds;
    dsx = qx - px;
    dsy = qy - py;
    dax = bx - ax;
    day = by - ay;
    wx  = ax - px;
    wy  = ay - py;
    den = cross2(dsx, dsy, dax, day);
    ds  = sgn(den);
    if (ds == 0) return 1'b0;
    tn = cross2(wx, wy, dax, day);
    un = cross2(wx, wy, dsx, dsy);
    return sgn(tn) * ds >= 0 && sgn(den - tn) * ds >= 0 &&
           sgn(un) * ds >= 0 && sgn(den - un) * ds >= 0;
  endfunction

  function automatic bit corner_on_segment(longint x, longint y, longint px, longint py,
                                           longint qx, longint qy);
    longint lox, hix, loy, hiy;
    lox = (px < qx) ? px : qx;
    hix = (px < qx) ? qx : px;
    loy = (py < qy) ? py : qy;
    hiy = (py < qy) ? qy : py;
    if (x < lox || x > hix || y < loy || y > hiy) return 1'b0;
    return cross2(qx - px, qy - py, x - px, y - py) == 0;
  endfunction

  function automatic logic hit_expected(pair_t p);
    longint px, py, qx, qy, x0, y0, x1, y1;
    longint cx[sri_pkg::NUM_CORNERS];
    longint cy[sri_pkg::NUM_CORNERS];
    logic   hit;
    px = longint'(p.sx);
    py = longint'(p.sy);
    qx = longint'(p.ex);
    qy = longint'(p.ey);
    x0 = longint'(p.rx);
    y0 = longint'(p.ry);
    x1 = x0 + longint'(p.w);
    y1 = y0 + longint'(p.h);
    cx[sri_pkg::CORNER_00] = x0;
    cy[sri_pkg::CORNER_00] = y0;
    cx[sri_pkg::CORNER_10] = x1;
    cy[sri_pkg::CORNER_10] = y0;
    cx[sri_pkg::CORNER_01] = x0;
    cy[sri_pkg::CORNER_01] = y1;
    cx[sri_pkg::CORNER_11] = x1;
    cy[sri_pkg::CORNER_11] = y1;
    hit = 1'b0;
    for (int c = 0; c < sri_pkg::NUM_CORNERS; c++)
      if (corner_on_segment(cx[c], cy[c], px, py, qx, qy)) hit = 1'b1;
    if (!hit)
      hit = side_crossed(px, py, qx, qy, x0, y0, x1, y0) ||
            side_crossed(px, py, qx, qy, x1, y0, x1, y1) ||
            side_crossed(px, py, qx, qy, x1, y1, x0, y1) ||
            side_crossed(px, py, qx, qy, x0, y1, x0, y0);
    return hit;
  endfunction

  function automatic pair_t make_pair(int sx, int sy, int ex, int ey,
                                      int rx, int ry, int w, int h);
    pair_t p;
    p.sx = to_coord(sx);
    p.sy = to_coord(sy);
    p.ex = to_coord(ex);
    p.ey = to_coord(ey);
    p.rx = to_coord(rx);
    p.ry = to_coord(ry);
    p.w  = to_size(w);
    p.h  = to_size(h);
    return p;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(6, 0))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    kind, base, cx, cy, px, py, dx, dy, a, b, w, h;
    kind = $urandom_range(99, 0);
    p = make_pair($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    if (kind < 15) begin
      if ($urandom_range(3, 0) == 0) begin
        p.sx = to_coord(extreme_coord());
        p.ey = to_coord(extreme_coord());
        p.rx = to_coord(extreme_coord());
        p.w  = $urandom_range(1, 0) ? 15'h7fff : 15'h0000;
      end
    end else if (kind < 40) begin
      // cluster everything in a tiny window so exact touches are common
      base = $urandom_range(65535, 0) - 32768;
      p = make_pair(base + $urandom_range(16, 0) - 8, base + $urandom_range(16, 0) - 8,
                    base + $urandom_range(16, 0) - 8, base + $urandom_range(16, 0) - 8,
                    base + $urandom_range(16, 0) - 8, base + $urandom_range(16, 0) - 8,
                    $urandom_range(12, 0), $urandom_range(12, 0));
    end else begin
      if ($urandom_range(3, 0) != 0) begin
        p.w = to_size($urandom_range(2000, 0));
        p.h = to_size($urandom_range(2000, 0));
      end
      w  = int'(p.w);
      h  = int'(p.h);
      cx = int'(p.rx) + ($urandom_range(1, 0) ? w : 0);
      cy = int'(p.ry) + ($urandom_range(1, 0) ? h : 0);
      case ($urandom_range(3, 0))
        0:       begin px = int'(p.rx) + $urandom_range(w, 0); py = int'(p.ry);     end
        1:       begin px = int'(p.rx) + $urandom_range(w, 0); py = int'(p.ry) + h; end
        2:       begin px = int'(p.rx);     py = int'(p.ry) + $urandom_range(h, 0); end
        default: begin px = int'(p.rx) + w; py = int'(p.ry) + $urandom_range(h, 0); end
      endcase
      if (kind < 60) begin
        // run the segment through a corner, sometimes nudged one step off
        dx = $urandom_range(40, 0) - 20;
        dy = $urandom_range(40, 0) - 20;
        a  = $urandom_range(5, 0);
        b  = $urandom_range(5, 0);
        p.sx = to_coord(cx - a * dx);
        p.sy = to_coord(cy - a * dy);
        p.ex = to_coord(cx + b * dx);
        p.ey = to_coord(cy + b * dy);
        if ($urandom_range(3, 0) == 0)
          p.ex = to_coord(int'(p.ex) + ($urandom_range(1, 0) ? 1 : -1));
      end else if (kind < 75) begin
        p.sx = to_coord(px);
        p.sy = to_coord(py);
        p.ex = to_coord(px + $urandom_range(6000, 0) - 3000);
        p.ey = to_coord(py + $urandom_range(6000, 0) - 3000);
        if ($urandom_range(1, 0)) begin
          p.ex = p.sx;
          p.sx = to_coord(px + $urandom_range(6000, 0) - 3000);
        end
      end else if (kind < 85) begin
        case ($urandom_range(2, 0))
          0:       begin p.sx = to_coord(cx); p.sy = to_coord(cy); end
          1:       begin p.sx = to_coord(px); p.sy = to_coord(py); end
          default: begin
            p.sx = to_coord(int'(p.rx) + $urandom_range(w + 4, 0) - 2);
            p.sy = to_coord(int'(p.ry) + $urandom_range(h + 4, 0) - 2);
          end
        endcase
        p.ex = p.sx;
        p.ey = p.sy;
      end else begin
        p.sx = to_coord(int'(p.rx) + $urandom_range(w + 4000, 0) - 2000);
        p.sy = to_coord(int'(p.ry) + $urandom_range(h + 4000, 0) - 2000);
        p.ex = to_coord(int'(p.rx) + $urandom_range(w + 4000, 0) - 2000);
        p.ey = to_coord(int'(p.ry) + $urandom_range(h + 4000, 0) - 2000);
      end
    end
    return p;
  endfunction

  // driver: hold the offered pair until its transaction, then advance
  always @(posedge clk) begin
    if (rst) begin
      pair_if.valid <= 1'b0;
    end else begin
      if (pair_if.valid && pair_if.ready)
        hit_queue.push_back('{offered, hit_expected(offered)});
      if (!pair_if.valid || pair_if.ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          offered = pending_pairs.pop_front();
          pair_if.seg_start_x <= offered.sx;
          pair_if.seg_start_y <= offered.sy;
          pair_if.seg_end_x   <= offered.ex;
          pair_if.seg_end_y   <= offered.ey;
          pair_if.rect_x      <= offered.rx;
          pair_if.rect_y      <= offered.ry;
          pair_if.rect_width  <= offered.w;
          pair_if.rect_height <= offered.h;
          pair_if.valid       <= 1'b1;
        end else begin
          pair_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    hit_entry_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (hit_queue.size() == 0) begin
          if (errors < 10) $display("unexpected result: hit %b", result_if.hit);
          errors++;
        end else begin
          want = hit_queue.pop_front();
          if (result_if.hit !== want.hit) begin
            if (errors < 10)
              $display("mismatch: seg (%0d,%0d)-(%0d,%0d) rect (%0d,%0d) %0dx%0d exp %b got %b",
                       want.p.sx, want.p.sy, want.p.ex, want.p.ey, want.p.rx, want.p.ry,
                       want.p.w, want.p.h, want.hit, result_if.hit);
            errors++;
          end
        end
      end
      result_if.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= stall_pct);
    end
  end

  task automatic drain_all();
    while (pending_pairs.size() != 0 || pair_if.valid || hit_queue.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_pairs.push_back(random_pair());
  endtask

  initial begin
    rst                 = 1'b1;
    errors              = 0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    hold_request        = 1'b0;
    pair_if.valid       = 1'b0;
    pair_if.seg_start_x = '0;
    pair_if.seg_start_y = '0;
    pair_if.seg_end_x   = '0;
    pair_if.seg_end_y   = '0;
    pair_if.rect_x      = '0;
    pair_if.rect_y      = '0;
    pair_if.rect_width  = '0;
    pair_if.rect_height = '0;
    result_if.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_pairs.push_back(make_pair(-100, 50, 300, 50, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(-100, -50, 300, -50, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(50, 50, 150, 60, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(-50, 0, 250, 0, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(300, 0, 400, 0, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(50, 20, 150, 20, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(200, 100, 200, 100, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(100, 0, 100, 0, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(0, 50, 0, 50, 0, 0, 0, 100));
    pending_pairs.push_back(make_pair(-10, 50, 10, 50, 0, 0, 0, 100));
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 5, 5, 0, 0));
    pending_pairs.push_back(make_pair(0, 1, 10, 11, 5, 5, 0, 0));
    pending_pairs.push_back(make_pair(100, -50, 100, 0, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                      -32768, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
                                      32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 0, 32767, 0, 32767, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 32767, 32767, -32768, -1, -1, 2, 2));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 1, 200, 101, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(-1, 0, -1, 100, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(-100, -100, 0, 0, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(-100, -100, -1, -1, 0, 0, 200, 100));
    pending_pairs.push_back(make_pair(-600, -375, -300, -375, -500, -400, 100, 50));
    pending_pairs.push_back(make_pair(-1, -1, 0, 0, -32768, -32768, 32767, 32767));
    drain_all();

    for (int round = 0; round < 2; round++) begin
      for (int ph = 0; ph < 4; ph++) begin
        case (ph)
          0:       begin send_idle_pct = 0;  stall_pct = 0;  end
          1:       begin send_idle_pct = 46; stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  stall_pct = 46; end
          default: begin send_idle_pct = 30; stall_pct = 30; end
        endcase
        queue_random(RANDOM_PER_PHASE);
        if (round == 0 && ph == 0) begin
          repeat (20) @(negedge clk);
          hold_request = 1'b1;
          @(negedge clk);
          hold_request = 1'b0;
        end
        drain_all();
      end
    end

    repeat (16) @(negedge clk);
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
rtl/sri_pkg.sv
rtl/sri_in_if.sv
rtl/sri_out_if.sv
rtl/sri_prep.sv
rtl/sri_decide.sv
rtl/segment_rectangle_intersect_core.sv
tb/segment_rectangle_intersect_core_tb.sv
